// File: hdl/ilvq_pkg.sv
package ilvq_pkg;

  // Default sizes for the top-level parameters.
  localparam int LEVELS_DEF      = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  // Fixed field widths of the item and result.
  localparam int ACTION_W = 2;
  localparam int VECTOR_W = 8;
  localparam int LEVEL_W  = 3;

  // Depth of the command queue between the front and the back.
  localparam int CMD_DEPTH   = 2;
  localparam int CMD_PTR_W   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

  // Action codes as they arrive on the command channel.
  typedef enum logic [ACTION_W-1:0] {
    ACT_INJECT = 2'd0,
    ACT_ACK    = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  // A classified command as it travels from the front to the back.
  typedef struct packed {
    action_t             op;
    logic                level_ok;
    logic [LEVEL_W-1:0]  level;
    logic [VECTOR_W-1:0] vector;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [VECTOR_W-1:0] vector;
    logic                use_autovector;
    logic                found;
    logic [LEVEL_W-1:0]  ipl;
    logic                dropped;
  } rsp_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ACK,
    BK_SCAN,
    BK_QDONE
  } back_state_t;

endpackage

// File: hdl/leveled_interrupt_vector_queue.sv
// Leveled interrupt vector queue: one vector FIFO per priority level and a
// requested interrupt priority level (IPL) derived from the non-empty FIFOs.
// Command channel: cmd_valid/cmd_stall with action, vector_in and level_in.
// Action 0 injects a vector, 1 acknowledges a level and pops its oldest
// vector, 2 asks whether a vector is pending at a level, 3 does nothing.
// Response channel: rsp_valid/rsp_stall with vector_out, use_autovector,
// found, ipl_out and dropped; exactly one response per command, in order.
// A command reaches the back end in the cycle after its transfer. Inject,
// no-op and refused commands are answered straight from idle; an acknowledge
// first reads the vector store, and a query reads and compares one entry per
// cycle, oldest first, up to the level's fill, since the store has one read port.
// A two-entry command queue lets the front keep taking commands while the
// back works, so injects sustain one per cycle while the receiver does not stall.
// When the receiver stalls, the response register holds its result and the
// back waits; once the command queue fills, cmd_stall rises.
// Reset clears all queues and sets the IPL to zero; the vector store itself
// is not cleared and needs no clearing pass.
module leveled_interrupt_vector_queue #(
  parameter int LEVELS      = ilvq_pkg::LEVELS_DEF,
  parameter int QUEUE_DEPTH = ilvq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  logic [ilvq_pkg::ACTION_W-1:0]  action,
  input  logic [ilvq_pkg::VECTOR_W-1:0]  vector_in,
  input  logic [ilvq_pkg::LEVEL_W-1:0]   level_in,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [ilvq_pkg::VECTOR_W-1:0]  vector_out,
  output logic                           use_autovector,
  output logic                           found,
  output logic [ilvq_pkg::LEVEL_W-1:0]   ipl_out,
  output logic                           dropped
);

  logic           q_valid;
  logic           q_pop;
  ilvq_pkg::cmd_t q_cmd;
  ilvq_pkg::rsp_t rsp;

  ilvq_front #(
    .LEVELS (LEVELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .action    (action),
    .vector_in (vector_in),
    .level_in  (level_in),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  ilvq_back #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Unpack the response register onto the field ports.
  assign vector_out     = rsp.vector;
  assign use_autovector = rsp.use_autovector;
  assign found          = rsp.found;
  assign ipl_out        = rsp.ipl;
  assign dropped        = rsp.dropped;

endmodule

// File: hdl/ilvq_front.sv
module ilvq_front #(
  parameter int LEVELS = ilvq_pkg::LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  logic [ilvq_pkg::ACTION_W-1:0]  action,
  input  logic [ilvq_pkg::VECTOR_W-1:0]  vector_in,
  input  logic [ilvq_pkg::LEVEL_W-1:0]   level_in,
  output logic                           q_valid,
  output ilvq_pkg::cmd_t                 q_cmd,
  input  logic                           q_pop
);

  ilvq_pkg::cmd_t                   fifo_mem [ilvq_pkg::CMD_DEPTH];
  logic [ilvq_pkg::CMD_PTR_W-1:0]   wr_ptr;
  logic [ilvq_pkg::CMD_PTR_W-1:0]   rd_ptr;
  logic [ilvq_pkg::CMD_CNT_W-1:0]   cnt;
  ilvq_pkg::cmd_t                   cmd_class;
  logic                             push;

  // Classify the incoming item: decode the action and check the level range.
  always_comb begin
    cmd_class.op       = ilvq_pkg::action_t'(action);
    cmd_class.level_ok = (32'(level_in) < LEVELS);
    cmd_class.level    = level_in;
    cmd_class.vector   = vector_in;
  end

  assign cmd_stall = (cnt == ilvq_pkg::CMD_CNT_W'(ilvq_pkg::CMD_DEPTH));
  assign push      = cmd_valid && !cmd_stall;
  assign q_valid   = (cnt != '0);
  assign q_cmd     = fifo_mem[rd_ptr];

  // Queue storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= cmd_class;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ilvq_pkg::CMD_PTR_W'(ilvq_pkg::CMD_DEPTH - 1)) ?
                  '0 : wr_ptr + ilvq_pkg::CMD_PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == ilvq_pkg::CMD_PTR_W'(ilvq_pkg::CMD_DEPTH - 1)) ?
                  '0 : rd_ptr + ilvq_pkg::CMD_PTR_W'(1);
      end
      if (push && !q_pop) begin
        cnt <= cnt + ilvq_pkg::CMD_CNT_W'(1);
      end else if (!push && q_pop) begin
        cnt <= cnt - ilvq_pkg::CMD_CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/ilvq_back.sv
module ilvq_back #(
  parameter int LEVELS      = ilvq_pkg::LEVELS_DEF,
  parameter int QUEUE_DEPTH = ilvq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  ilvq_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ilvq_pkg::rsp_t rsp
);

  localparam int LIW = $clog2(LEVELS);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int PW  = CW + 1;
  localparam int SD  = LEVELS * QUEUE_DEPTH;
  localparam int AW  = $clog2(SD);

  ilvq_pkg::back_state_t state, state_next;

  // Per-level queue bookkeeping and the shared vector store.
  logic [HW-1:0]                  heads  [LEVELS];
  logic [CW-1:0]                  counts [LEVELS];
  logic [ilvq_pkg::VECTOR_W-1:0]  store  [SD];
  logic [ilvq_pkg::VECTOR_W-1:0]  rd_data;
  logic [ilvq_pkg::LEVEL_W-1:0]   ipl;

  // Registers of the command in progress.
  logic [LIW-1:0]                 cur_level;
  logic [ilvq_pkg::VECTOR_W-1:0]  cur_vector;
  logic [CW-1:0]                  scan_idx;
  logic                           found_q;

  // Control decided by the sequencer.
  logic                           can_load;
  logic                           rsp_load;
  ilvq_pkg::rsp_t                 rsp_new;
  logic [ilvq_pkg::LEVEL_W-1:0]   ipl_new;
  logic [LIW-1:0]                 act_lvl;
  logic [HW-1:0]                  act_head;
  logic [CW-1:0]                  act_cnt;
  logic [CW-1:0]                  addr_off;
  logic [PW-1:0]                  pos;
  logic [PW-1:0]                  head_inc;
  logic [AW-1:0]                  addr;
  logic                           rd_en;
  logic                           wr_en;
  logic                           cnt_upd;
  logic [CW-1:0]                  cnt_new;
  logic                           head_upd;
  logic [HW-1:0]                  head_new;
  logic [CW-1:0]                  scan_nxt;
  logic                           start_ack;
  logic                           start_scan;
  logic                           scan_end;
  logic                           scan_hit;
  logic                           mod_set;
  logic                           mod_clr;
  logic [LEVELS-1:0]              nz;
  logic                           nz_any;
  logic [ilvq_pkg::LEVEL_W-1:0]   nz_hi;
  logic                           is_full;
  logic                           is_empty;

  assign can_load = !rsp_valid || !rsp_stall;

  // One level is addressed per cycle: the new command's in idle, else the latched one.
  assign act_lvl  = (state == ilvq_pkg::BK_IDLE) ? q_cmd.level[LIW-1:0] : cur_level;
  assign act_head = heads[act_lvl];
  assign act_cnt  = counts[act_lvl];
  assign is_full  = (act_cnt == CW'(QUEUE_DEPTH));
  assign is_empty = (act_cnt == '0);
  assign scan_nxt = scan_idx + CW'(1);

  // Slot address: level base plus the position wrapped once around the queue.
  always_comb begin
    pos = PW'(act_head) + PW'(addr_off);
    if (pos >= PW'(QUEUE_DEPTH)) begin
      pos = pos - PW'(QUEUE_DEPTH);
    end
    addr = AW'(act_lvl) * AW'(QUEUE_DEPTH) + AW'(pos);
  end

  // Head advance after a pop.
  always_comb begin
    head_inc = PW'(act_head) + PW'(1);
    head_new = (head_inc >= PW'(QUEUE_DEPTH)) ? '0 : HW'(head_inc);
  end

  // Occupancy map with the pending push or pop folded in, then the top level above zero.
  always_comb begin
    for (int lv = 0; lv < LEVELS; lv++) begin
      nz[lv] = (counts[lv] != '0);
    end
    if (mod_set) begin
      nz[act_lvl] = 1'b1;
    end
    if (mod_clr) begin
      nz[act_lvl] = 1'b0;
    end
    nz_any = 1'b0;
    nz_hi  = '0;
    for (int lv = 1; lv < LEVELS; lv++) begin
      if (nz[lv]) begin
        nz_any = 1'b1;
        nz_hi  = ilvq_pkg::LEVEL_W'(lv);
      end
    end
  end

  assign scan_hit = (rd_data == cur_vector);
  assign scan_end = (scan_nxt == act_cnt);

  // Sequencer: next state, result and bookkeeping updates.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rsp_load   = 1'b0;
    rsp_new    = '0;
    ipl_new    = ipl;
    addr_off   = '0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    cnt_upd    = 1'b0;
    cnt_new    = act_cnt;
    head_upd   = 1'b0;
    mod_set    = 1'b0;
    mod_clr    = 1'b0;
    start_ack  = 1'b0;
    start_scan = 1'b0;
    unique case (state)
      ilvq_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            ilvq_pkg::ACT_INJECT: begin
              if (can_load) begin
                q_pop    = 1'b1;
                rsp_load = 1'b1;
                addr_off = act_cnt;
                if (q_cmd.level_ok && !is_full) begin
                  wr_en   = 1'b1;
                  cnt_upd = 1'b1;
                  cnt_new = act_cnt + CW'(1);
                  mod_set = 1'b1;
                end
                if (q_cmd.level_ok && nz_any) begin
                  ipl_new = nz_hi;
                end
                rsp_new.dropped = !q_cmd.level_ok || is_full;
                rsp_new.ipl     = ipl_new;
              end
            end
            ilvq_pkg::ACT_ACK: begin
              if (q_cmd.level_ok && !is_empty) begin
                q_pop      = 1'b1;
                rd_en      = 1'b1;
                start_ack  = 1'b1;
                state_next = ilvq_pkg::BK_ACK;
              end else if (can_load) begin
                q_pop                  = 1'b1;
                rsp_load               = 1'b1;
                rsp_new.use_autovector = 1'b1;
                rsp_new.ipl            = ipl;
              end
            end
            ilvq_pkg::ACT_QUERY: begin
              if (q_cmd.level_ok && !is_empty) begin
                q_pop      = 1'b1;
                rd_en      = 1'b1;
                start_scan = 1'b1;
                state_next = ilvq_pkg::BK_SCAN;
              end else if (can_load) begin
                q_pop       = 1'b1;
                rsp_load    = 1'b1;
                rsp_new.ipl = ipl;
              end
            end
            default: begin
              if (can_load) begin
                q_pop       = 1'b1;
                rsp_load    = 1'b1;
                rsp_new.ipl = ipl;
              end
            end
          endcase
        end
      end
      ilvq_pkg::BK_ACK: begin
        // The head vector was read when the acknowledge was taken and holds in rd_data.
        if (can_load) begin
          rsp_load       = 1'b1;
          cnt_upd        = 1'b1;
          cnt_new        = act_cnt - CW'(1);
          head_upd       = 1'b1;
          mod_clr        = (act_cnt == CW'(1));
          ipl_new        = nz_any ? nz_hi : '0;
          rsp_new.vector = rd_data;
          rsp_new.ipl    = ipl_new;
          state_next     = ilvq_pkg::BK_IDLE;
        end
      end
      ilvq_pkg::BK_SCAN: begin
        // Compare one entry a cycle, oldest first, and fetch the next one.
        if (scan_hit || scan_end) begin
          state_next = ilvq_pkg::BK_QDONE;
        end else begin
          addr_off = scan_nxt;
          rd_en    = 1'b1;
        end
      end
      ilvq_pkg::BK_QDONE: begin
        if (can_load) begin
          rsp_load      = 1'b1;
          rsp_new.found = found_q;
          rsp_new.ipl   = ipl;
          state_next    = ilvq_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = ilvq_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilvq_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Vector store with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[addr] <= q_cmd.vector;
    end
    if (rd_en) begin
      rd_data <= store[addr];
    end
  end

  // Queue heads, counts and the requested level.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int lv = 0; lv < LEVELS; lv++) begin
        heads[lv]  <= '0;
        counts[lv] <= '0;
      end
      ipl <= '0;
    end else begin
      if (cnt_upd) begin
        counts[act_lvl] <= cnt_new;
      end
      if (head_upd) begin
        heads[act_lvl] <= head_new;
      end
      if (rsp_load) begin
        ipl <= ipl_new;
      end
    end
  end

  // Latched command for the multi-cycle operations.
  always_ff @(posedge clk) begin
    if (start_ack || start_scan) begin
      cur_level  <= act_lvl;
      cur_vector <= q_cmd.vector;
      scan_idx   <= '0;
    end else if (state == ilvq_pkg::BK_SCAN && !scan_hit && !scan_end) begin
      scan_idx <= scan_nxt;
    end
    if (state == ilvq_pkg::BK_SCAN) begin
      found_q <= scan_hit;
    end
  end

  // Result register; it parts the back from the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_new;
    end
  end

endmodule

// File: hdl/ilvq_checker.sv
module ilvq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cmd_valid,
  input logic                           cmd_stall,
  input logic [ilvq_pkg::ACTION_W-1:0]  action,
  input logic [ilvq_pkg::VECTOR_W-1:0]  vector_in,
  input logic [ilvq_pkg::LEVEL_W-1:0]   level_in,
  input logic                           rsp_valid,
  input logic                           rsp_stall,
  input logic [ilvq_pkg::VECTOR_W-1:0]  vector_out,
  input logic                           use_autovector,
  input logic                           found,
  input logic [ilvq_pkg::LEVEL_W-1:0]   ipl_out,
  input logic                           dropped
);

  // Reset leaves no response pending and the command queue open.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid && !cmd_stall)
    else $error("response pending or command stall after reset");

  // A stalled response keeps all of its fields.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(vector_out) &&
      $stable(use_autovector) && $stable(found) && $stable(ipl_out) && $stable(dropped))
    else $error("stalled response changed");

  // A response answers one kind of command, so at most one flag is set.
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $countones({use_autovector, found, dropped}) <= 1)
    else $error("response carries more than one flag");

  // An autovector answer carries no vector.
  a_autovector_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && use_autovector |-> vector_out == '0)
    else $error("autovector response with a vector");

endmodule

bind leveled_interrupt_vector_queue ilvq_checker u_ilvq_checker (.*);
